### src/gol_pkg.sv
// ----------------------------------------------------------------------------
// gol_pkg
// Shared types, constants and helpers for the grid overlay pixel stream.
// ----------------------------------------------------------------------------
`default_nettype none

package gol_pkg;

  // Default sizing of the line position tables
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_LINES  = 15;

  // Register reset values
  localparam logic [3:0]  RST_GRID_LINES    = 4'd0;
  localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
  localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;

  // Brightness threshold (3 * 127) and the white and black levels
  localparam logic [9:0] LUMA_THRESH = 10'd381;
  localparam logic [7:0] PIX_WHITE   = 8'd255;
  localparam logic [7:0] PIX_BLACK   = 8'd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GRID_LINES    = 2'd0,
    REG_FRAME_WIDTH   = 2'd1,
    REG_FRAME_HEIGHT  = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       start_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       on_grid;
  } pix_out_t;

  // Effective frame size: zero reads as one, above the cap reads as the cap
  function automatic logic [31:0] eff_size(logic [11:0] size_reg, int cap);
    logic [31:0] s;
    s = 32'(size_reg);
    if (s == 32'd0) begin
      return 32'd1;
    end
    if (s > 32'(cap)) begin
      return 32'(cap);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### src/grid_overlay_pixel_stream.sv
// ----------------------------------------------------------------------------
// grid_overlay_pixel_stream
// Draws evenly spaced grid lines over a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Pixels enter on in_valid/in_stall/in_data; a transfer happens when valid
//    is high and stall low. start_of_frame clears the column and row counters.
//  - Results leave on out_valid/out_stall/out_data, one per pixel, in order,
//    in the cycle after the input transfer (single output register).
//  - Throughput is one pixel per cycle while no rebuild or receiver stall holds
//    the input. A pixel is checked against all line position registers in parallel, so nothing loops per pixel.
//  - The cfg port (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    line count, frame_width and frame_height; other indexes are ignored.
//  - After reset and after each register write the line positions are
//    rebuilt: a clear step, then with a nonzero line count the serial
//    divider takes one step per spacing bit (28 bits with the default sizes),
//    one step places the centre line(s) or first pair and one step each
//    further mirrored pair; with zero lines only the clear step runs. in_stall stays high meanwhile.
//  - When the receiver stalls, the output register holds and in_stall rises
//    until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_overlay_pixel_stream import gol_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_LINES  = DEF_MAX_LINES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pix_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pix_out_t      out_data,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int NS = MAX_LINES + 1;

  logic [3:0]    grid_lines;
  logic [11:0]   frame_width;
  logic [11:0]   frame_height;
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;

  logic          cfg_write;
  logic          rebuild;
  logic          col_busy;
  logic          row_busy;
  logic [XW-1:0] col_pos [NS];
  logic          col_vld [NS];
  logic [YW-1:0] row_pos [NS];
  logic          row_vld [NS];

  logic          accept;
  logic [XW:0]   w;
  logic [YW:0]   h;
  logic [XW-1:0] cc;
  logic [YW-1:0] rc;
  logic [XW:0]   cc_inc;
  logic [YW:0]   rc_inc;
  logic [XW-1:0] column_count_next;
  logic [YW-1:0] row_count_next;
  logic [NS-1:0] col_hit;
  logic [NS-1:0] row_hit;
  logic          any_hit;
  logic          odd_hit;
  logic [9:0]    luma;
  logic          black;
  pix_out_t      res;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign rebuild   = cfg_write & (cfg_index != REG_UNUSED);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_lines    <= RST_GRID_LINES;
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_LINES:    grid_lines    <= cfg_data[3:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line position builders
  gol_builder #(.MAX_SIZE(MAX_WIDTH), .MAX_LINES(MAX_LINES)) u_col_bld (
    .clk(clk), .rst(rst), .start(rebuild), .size_reg(frame_width),
    .lines_reg(grid_lines), .busy(col_busy), .pos(col_pos), .vld(col_vld)
  );

  gol_builder #(.MAX_SIZE(MAX_HEIGHT), .MAX_LINES(MAX_LINES)) u_row_bld (
    .clk(clk), .rst(rst), .start(rebuild), .size_reg(frame_height),
    .lines_reg(grid_lines), .busy(row_busy), .pos(row_pos), .vld(row_vld)
  );

  assign in_stall = col_busy | row_busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Position of this pixel and of the next one
  always_comb begin
    w = (XW+1)'(eff_size(frame_width, MAX_WIDTH));
    h = (YW+1)'(eff_size(frame_height, MAX_HEIGHT));
    if (in_data.start_of_frame || ({1'b0, column_count} >= w)) begin
      cc = '0;
    end else begin
      cc = column_count;
    end
    if (in_data.start_of_frame || ({1'b0, row_count} >= h)) begin
      rc = '0;
    end else begin
      rc = row_count;
    end
    cc_inc = {1'b0, cc} + (XW+1)'(1);
    rc_inc = {1'b0, rc} + (YW+1)'(1);
    if (cc_inc >= w) begin
      column_count_next = '0;
      row_count_next    = (rc_inc >= h) ? '0 : rc_inc[YW-1:0];
    end else begin
      column_count_next = cc_inc[XW-1:0];
      row_count_next    = rc;
    end
  end

  // Hit detection against every line slot, then recolor
  always_comb begin
    for (int i = 0; i < NS; i++) begin
      col_hit[i] = col_vld[i] && (col_pos[i] == cc);
      row_hit[i] = row_vld[i] && (row_pos[i] == rc);
    end
    any_hit = (|col_hit) | (|row_hit);
    odd_hit = (^col_hit) ^ (^row_hit);
    luma    = 10'(in_data.red_in) + 10'(in_data.green_in) + 10'(in_data.blue_in);
    black   = (luma > LUMA_THRESH) ^ ~odd_hit;
    res.on_grid = any_hit;
    if (any_hit) begin
      res.red_out   = black ? PIX_BLACK : PIX_WHITE;
      res.green_out = black ? PIX_BLACK : PIX_WHITE;
      res.blue_out  = black ? PIX_BLACK : PIX_WHITE;
    end else begin
      res.red_out   = in_data.red_in;
      res.green_out = in_data.green_in;
      res.blue_out  = in_data.blue_in;
    end
  end

  // Counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  // No pixel taken while line positions are being rebuilt
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> !col_busy && !row_busy)
    else $error("pixel accepted during rebuild");

  // Grid pixels are pure black or pure white
  a_grid_bw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.on_grid) |->
      (out_data.red_out == out_data.green_out) &&
      (out_data.green_out == out_data.blue_out) &&
      ((out_data.red_out == PIX_BLACK) || (out_data.red_out == PIX_WHITE)))
    else $error("grid pixel not black or white");

  // Zero lines means no grid hit
  a_zero_lines: assert property (@(posedge clk) disable iff (rst)
    (accept && (grid_lines == '0)) |=> !out_data.on_grid)
    else $error("grid hit with zero lines");

  // An accepted pixel always shows up at the output
  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted pixel lost");

endmodule

`default_nettype wire

### src/gol_builder.sv
// ----------------------------------------------------------------------------
// gol_builder
// Builds the grid line positions of one direction: a bit-serial divider for
// the 12.16 spacing, then the centre line(s) or one mirrored pair per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gol_builder import gol_pkg::*; #(
  parameter int MAX_SIZE  = DEF_MAX_WIDTH,
  parameter int MAX_LINES = DEF_MAX_LINES,
  localparam int CW = $clog2(MAX_SIZE),
  localparam int NS = MAX_LINES + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [11:0]   size_reg,
  input  wire logic [3:0]    lines_reg,
  output logic               busy,
  output logic [CW-1:0]      pos [NS],
  output logic               vld [NS]
);

  localparam int SW  = $clog2(MAX_SIZE + 1);
  localparam int LW  = $clog2(MAX_LINES + 1);
  localparam int DVW = LW + 1;
  localparam int DW  = SW + 16;
  localparam int IW  = DW + 2;
  localparam int RW  = IW - 16 + 2;
  localparam int PTW = (NS > 1) ? $clog2(NS) : 1;
  localparam int BCW = $clog2(DW + 1);

  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_PREP  = 5'b00100,
    ST_GEN   = 5'b01000,
    ST_DONE  = 5'b10000
  } bld_state_t;

  bld_state_t              state;
  logic [DW-1:0]           dsh;
  logic [DVW-1:0]          rmd;
  logic [DW-1:0]           quo;
  logic [BCW-1:0]          bitc;
  logic signed [IW-1:0]    idx;
  logic [LW-1:0]           remc;
  logic [PTW-1:0]          ptr;

  logic [SW-1:0]           sz;
  logic [LW-1:0]           n;
  logic [DW-1:0]           dividend;
  logic [DVW-1:0]          divisor;
  logic [DVW:0]            trial;
  logic signed [RW-1:0]    sz_s;
  logic signed [IW-1:0]    g_s;
  logic signed [IW-1:0]    idx_gen;
  logic signed [IW-1:0]    idx_even;
  logic signed [RW-1:0]    ra;
  logic signed [RW-1:0]    rb;

  // Round signed 14.16 (default sizes) to integer, half away from zero
  function automatic logic signed [RW-1:0] rnd(logic signed [IW-1:0] v);
    logic [IW-1:0]        m;
    logic signed [RW-1:0] q;
    m = v[IW-1] ? IW'(-v) : IW'(v);
    m = m + IW'(32768);
    q = $signed({2'b00, m[IW-1:16]});
    return v[IW-1] ? -q : q;
  endfunction

  function automatic logic in_range(logic signed [RW-1:0] p, logic signed [RW-1:0] s);
    return (p >= 0) && (p < s);
  endfunction

  // Effective size and line count
  always_comb begin
    sz       = SW'(eff_size(size_reg, MAX_SIZE));
    n        = (32'(lines_reg) > 32'(MAX_LINES)) ? LW'(MAX_LINES) : LW'(lines_reg);
    dividend = {sz, 16'b0} + DW'((32'(n) + 32'd1) >> 1);
    divisor  = DVW'(n) + DVW'(1);
    trial    = {rmd, dsh[DW-1]};
    sz_s     = $signed(RW'(sz));
    g_s      = $signed(IW'(quo));
    idx_gen  = idx - g_s;
    idx_even = $signed(IW'(quo) * IW'(n >> 1));
    if (state == ST_PREP) begin
      ra = rnd(idx_even);
    end else begin
      ra = rnd(idx_gen);
    end
    rb = sz_s - RW'(1) - ra;
  end

  assign busy = (state != ST_DONE);

  // Sequencer: clear, divide, then place positions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
      for (int i = 0; i < NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (start) begin
      state <= ST_START;
    end else begin
      case (state)
        ST_START: begin
          for (int i = 0; i < NS; i++) begin
            vld[i] <= 1'b0;
          end
          dsh   <= dividend;
          rmd   <= '0;
          quo   <= '0;
          bitc  <= BCW'(DW);
          state <= (n == '0) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          dsh <= {dsh[DW-2:0], 1'b0};
          if (trial >= {1'b0, divisor}) begin
            rmd <= DVW'(trial - {1'b0, divisor});
            quo <= {quo[DW-2:0], 1'b1};
          end else begin
            rmd <= DVW'(trial);
            quo <= {quo[DW-2:0], 1'b0};
          end
          bitc <= bitc - BCW'(1);
          if (bitc == BCW'(1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (n[0]) begin
            // centre line, doubled for an even size
            pos[0] <= CW'(sz >> 1);
            vld[0] <= 1'b1;
            pos[1] <= CW'((sz >> 1) - SW'(1));
            vld[1] <= ~sz[0];
            idx    <= $signed(IW'(sz - SW'(1)) << 15);
          end else begin
            pos[0] <= ra[CW-1:0];
            vld[0] <= in_range(ra, sz_s);
            pos[1] <= rb[CW-1:0];
            vld[1] <= in_range(rb, sz_s);
            idx    <= idx_even;
          end
          remc  <= LW'((n - LW'(1)) >> 1);
          ptr   <= PTW'(2);
          state <= (((n - LW'(1)) >> 1) == '0) ? ST_DONE : ST_GEN;
        end
        ST_GEN: begin
          pos[ptr]           <= ra[CW-1:0];
          vld[ptr]           <= in_range(ra, sz_s);
          pos[ptr + PTW'(1)] <= rb[CW-1:0];
          vld[ptr + PTW'(1)] <= in_range(rb, sz_s);
          idx                <= idx_gen;
          ptr                <= ptr + PTW'(2);
          remc               <= remc - LW'(1);
          if (remc == LW'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: begin
          state <= ST_START;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### test/grid_overlay_pixel_stream_tb.sv
// ----------------------------------------------------------------------------
// grid_overlay_pixel_stream_tb
// Drives pixel frames through the grid overlay under several line counts and
// frame sizes. A local model of the line tables and the position counters
// predicts each output pixel, which is checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_overlay_pixel_stream_tb;
  import gol_pkg::*;

  localparam int  TBL_DEPTH   = 2048;
  localparam int  LINE_CAP    = 15;
  localparam int  CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  pix_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [11:0] cfg_data = 12'd0;

  grid_overlay_pixel_stream dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  pix_in_t  pixel_queue[$];
  pix_out_t overlay_queue[$];
  int       fail_count = 0;
  int       cycle_count = 0;
  logic     in_took = 1'b0;
  logic     gaps_on = 1'b1;

  // Local copy of registers, counters and line tables
  logic [3:0]  lines_reg;
  logic [11:0] width_reg, height_reg;
  int          col_pos, row_pos;
  logic [1:0]  col_tab[TBL_DEPTH];
  logic [1:0]  row_tab[TBL_DEPTH];

  function automatic int clamp_size(logic [11:0] r);
    if (r == 12'd0) return 1;
    return (int'(r) > TBL_DEPTH) ? TBL_DEPTH : int'(r);
  endfunction

  function automatic longint round_fix(longint v);
    if (v >= 0) return (v + 32768) / 65536;
    return -((-v + 32768) / 65536);
  endfunction

  function automatic void hit(bit is_col, int size, longint p);
    if (p >= 0 && p < size) begin
      if (is_col) col_tab[p] = {1'b1, ~col_tab[p][0]};
      else row_tab[p] = {1'b1, ~row_tab[p][0]};
    end
  endfunction

  // Centre-out line placement for one axis
  function automatic void place_lines(bit is_col, int size, int n);
    longint step, pos, sz;
    int     pairs;
    sz = size;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      if (is_col) col_tab[i] = 2'b00;
      else row_tab[i] = 2'b00;
    end
    if (n == 0) return;
    step = (sz * 65536 + longint'((n + 1) / 2)) / longint'(n + 1);
    if (n % 2 == 1) begin
      hit(is_col, size, sz / 2);
      if (size % 2 == 0) hit(is_col, size, sz / 2 - 1);
      pos = (sz - 1) * 32768;
    end else begin
      pos = step * longint'(n / 2);
      hit(is_col, size, round_fix(pos));
      hit(is_col, size, sz - 1 - round_fix(pos));
    end
    pairs = (n - 1) / 2;
    while (pairs > 0) begin
      pos -= step;
      hit(is_col, size, round_fix(pos));
      hit(is_col, size, sz - 1 - round_fix(pos));
      pairs--;
    end
  endfunction

  function automatic void refresh_tables();
    int n;
    n = (int'(lines_reg) > LINE_CAP) ? LINE_CAP : int'(lines_reg);
    place_lines(1'b1, clamp_size(width_reg), n);
    place_lines(1'b0, clamp_size(height_reg), n);
  endfunction

  // Expected overlay for one accepted pixel; advances the raster position
  function automatic pix_out_t overlay_pixel(pix_in_t px);
    pix_out_t   o;
    int         w, h;
    logic [1:0] ch, rh;
    logic       dark;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    if (px.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    ch = col_tab[col_pos];
    rh = row_tab[row_pos];
    o.red_out = px.red_in;
    o.green_out = px.green_in;
    o.blue_out = px.blue_in;
    o.on_grid = ch[1] | rh[1];
    if (o.on_grid) begin
      dark = (10'(px.red_in) + 10'(px.green_in) + 10'(px.blue_in)) > LUMA_THRESH;
      if ((ch[0] ^ rh[0]) == 1'b0) dark = ~dark;
      o.red_out = dark ? PIX_BLACK : PIX_WHITE;
      o.green_out = o.red_out;
      o.blue_out = o.red_out;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
    return o;
  endfunction

  // Driver: new pixel or idle on the falling edge; stalled payload holds
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      if (pixel_queue.size() > 0 && !(gaps_on && $urandom_range(99) < 12)) begin
        in_data <= pixel_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !rst && gaps_on && ($urandom_range(99) < 12);
  end

  // Monitor: predict on input transfer, check on output transfer
  always @(posedge clk) begin
    pix_out_t want;
    cycle_count <= cycle_count + 1;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) overlay_queue.push_back(overlay_pixel(in_data));
    if (!rst && out_valid && !out_stall) begin
      if (overlay_queue.size() == 0) begin
        $error("unexpected output transfer %h", out_data);
        fail_count++;
      end else begin
        want = overlay_queue.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $error("red_out exp %0d got %0d", want.red_out, out_data.red_out);
          fail_count++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out exp %0d got %0d", want.green_out, out_data.green_out);
          fail_count++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out exp %0d got %0d", want.blue_out, out_data.blue_out);
          fail_count++;
        end
        if (out_data.on_grid !== want.on_grid) begin
          $error("on_grid exp %0b got %0b", want.on_grid, out_data.on_grid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pixel_queue.size() > 0 || in_valid || overlay_queue.size() > 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GRID_LINES:    lines_reg = val[3:0];
      REG_FRAME_WIDTH:   width_reg = val;
      REG_FRAME_HEIGHT:  height_reg = val;
      default: ;
    endcase
    refresh_tables();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup(logic [3:0] n, logic [11:0] w, logic [11:0] h);
    drain();
    write_reg(REG_GRID_LINES, {8'($urandom), n});
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic push_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic sof);
    pix_in_t px;
    px.red_in = r;
    px.green_in = g;
    px.blue_in = b;
    px.start_of_frame = sof;
    pixel_queue.push_back(px);
  endtask

  // Random frames: mostly whole frames with start marks, some stray marks
  task automatic random_frames(int count, int frame_len);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        r = 8'($urandom_range(120, 135));
        g = 8'($urandom_range(120, 135));
        b = 8'($urandom_range(120, 135));
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
      push_px(r, g, b, (i % frame_len == 0) || ($urandom_range(99) < 3));
    end
  endtask

  initial begin
    lines_reg = RST_GRID_LINES;
    width_reg = RST_FRAME_WIDTH;
    height_reg = RST_FRAME_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    refresh_tables();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero lines at reset sizes: everything passes
    push_px(8'd0, 8'd0, 8'd0, 1'b1);
    push_px(8'd255, 8'd255, 8'd255, 1'b0);
    push_px(8'd127, 8'd127, 8'd128, 1'b0);

    // Small frame, odd count: threshold edges, crossings, mid-frame restart
    setup(4'd3, 12'd8, 12'd6);
    push_px(8'd127, 8'd127, 8'd127, 1'b1);
    push_px(8'd127, 8'd127, 8'd128, 1'b0);
    push_px(8'd255, 8'd255, 8'd255, 1'b0);
    push_px(8'd0, 8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 12; i++) push_px(8'(i * 21), 8'(255 - i * 20), 8'd128, 1'b0);
    push_px(8'd10, 8'd20, 8'd30, 1'b1);
    push_px(8'd200, 8'd200, 8'd200, 1'b0);
    drain();
    write_reg(REG_UNUSED, 12'hFFF);

    // Size zero reads as one; oversize reads as the cap
    setup(4'd15, 12'd0, 12'd0);
    random_frames(6, 1);
    setup(4'd15, 12'd4095, 12'd4095);
    random_frames(20, 4096);

    setup(4'd2, 12'd5, 12'd4);
    random_frames(60, 20);
    setup(4'd4, 12'd16, 12'd9);
    random_frames(60, 144);
    setup(4'd1, 12'd1, 12'd1);
    random_frames(15, 1);

    // Long stretch with no gaps on either side
    setup(4'd7, 12'd13, 12'd11);
    gaps_on = 1'b0;
    random_frames(90, 143);
    drain();
    gaps_on = 1'b1;

    setup(4'd15, 12'd31, 12'd4);
    random_frames(60, 124);
    setup(4'd6, 12'd20, 12'd3);
    random_frames(40, 60);
    setup(4'd5, 12'd2048, 12'd3);
    random_frames(20, 6144);
    setup(4'(8 + $urandom_range(7)), 12'($urandom_range(2, 24)), 12'($urandom_range(2, 8)));
    random_frames(40, 50);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
